### rtl/stl_pkg.sv
// shared types, constants and the word classifier of the source token lexer
// depends on nothing; every other file imports it
package stl_pkg;

  localparam int unsigned OffsetWidth = 24;
  localparam int unsigned LineWidth   = 20;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueueAddrW  = $clog2(QueueDepth);

  localparam logic [3:0] CLS_KEYWORD  = 4'd0;
  localparam logic [3:0] CLS_TYPENAME = 4'd1;
  localparam logic [3:0] CLS_IDENT    = 4'd2;
  localparam logic [3:0] CLS_INTEGER  = 4'd3;
  localparam logic [3:0] CLS_REAL     = 4'd4;
  localparam logic [3:0] CLS_STRING   = 4'd5;
  localparam logic [3:0] CLS_OPERATOR = 4'd6;
  localparam logic [3:0] CLS_PUNCT    = 4'd7;
  localparam logic [3:0] CLS_END      = 4'd8;
  localparam logic [3:0] CLS_ERROR    = 4'd9;

  localparam logic [3:0] VAR_NONE      = 4'd0;
  localparam logic [3:0] OP_BANG       = 4'd0;
  localparam logic [3:0] OP_SLASH      = 4'd1;
  localparam logic [3:0] OP_PLUS       = 4'd2;
  localparam logic [3:0] OP_MINUS      = 4'd3;
  localparam logic [3:0] OP_STAR       = 4'd4;
  localparam logic [3:0] OP_LESS       = 4'd5;
  localparam logic [3:0] OP_GREATER    = 4'd6;
  localparam logic [3:0] OP_PERCENT    = 4'd7;
  localparam logic [3:0] OP_EQEQ       = 4'd8;
  localparam logic [3:0] OP_SCOPE      = 4'd9;
  localparam logic [3:0] PU_SEMI       = 4'd0;
  localparam logic [3:0] PU_ASSIGN     = 4'd1;
  localparam logic [3:0] PU_ARROW      = 4'd2;
  localparam logic [3:0] PU_LBRACE     = 4'd3;
  localparam logic [3:0] PU_RBRACE     = 4'd4;
  localparam logic [3:0] PU_LPAREN     = 4'd5;
  localparam logic [3:0] PU_RPAREN     = 4'd6;
  localparam logic [3:0] PU_LBRACKET   = 4'd7;
  localparam logic [3:0] PU_RBRACKET   = 4'd8;
  localparam logic [3:0] PU_COMMA      = 4'd9;
  localparam logic [3:0] ERR_BAD_BYTE  = 4'd0;
  localparam logic [3:0] ERR_OPEN_STR  = 4'd1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  typedef struct packed {
    logic [3:0]             token_class;
    logic [3:0]             token_variant;
    logic [OffsetWidth-1:0] tok_offset;
    logic [OffsetWidth-1:0] token_length;
    logic [LineWidth-1:0]   line_number;
    logic [OffsetWidth-1:0] column_number;
  } stl_token_t;

  // all results of one input transaction, first then second
  typedef struct packed {
    logic       a_valid;
    logic       b_valid;
    stl_token_t a;
    stl_token_t b;
  } stl_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stl_q_status_t;

  // returns {class, variant} of a finished word
  function automatic logic [7:0] classify_word(logic [47:0] w, logic [2:0] n);
    logic [7:0] r;
    r = {CLS_IDENT, VAR_NONE};
    unique case (1'b1)
      (n == 3'd6 && w == 48'h72657475726e): r = {CLS_KEYWORD, 4'd0};
      (n == 3'd4 && w == 48'h000063617374): r = {CLS_KEYWORD, 4'd1};
      (n == 3'd2 && w == 48'h000000006966): r = {CLS_KEYWORD, 4'd2};
      (n == 3'd4 && w == 48'h0000656c7365): r = {CLS_KEYWORD, 4'd3};
      (n == 3'd5 && w == 48'h007768696c65): r = {CLS_KEYWORD, 4'd4};
      (n == 3'd4 && w == 48'h000074727565): r = {CLS_KEYWORD, 4'd5};
      (n == 3'd5 && w == 48'h0066616c7365): r = {CLS_KEYWORD, 4'd6};
      (n == 3'd5 && w == 48'h00627265616b): r = {CLS_KEYWORD, 4'd7};
      (n == 3'd3 && w == 48'h000000696e74): r = {CLS_TYPENAME, 4'd0};
      (n == 3'd4 && w == 48'h00007265616c): r = {CLS_TYPENAME, 4'd1};
      (n == 3'd4 && w == 48'h0000766f6964): r = {CLS_TYPENAME, 4'd2};
      (n == 3'd4 && w == 48'h0000626f6f6c): r = {CLS_TYPENAME, 4'd3};
      (n == 3'd4 && w == 48'h000063686172): r = {CLS_TYPENAME, 4'd4};
      (n == 3'd6 && w == 48'h737472696e67): r = {CLS_TYPENAME, 4'd5};
      default: r = {CLS_IDENT, VAR_NONE};
    endcase
    return r;
  endfunction

endpackage

### rtl/stl_in_if.sv
// input channel of the lexer: one source byte or end of file per transaction
// depends on stl_pkg
interface stl_in_if import stl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] source_byte;
  modport source (output valid, op, source_byte, input ready);
  modport sink (input valid, op, source_byte, output ready);
endinterface

### rtl/stl_out_if.sv
// output channel of the lexer: one token per transaction
// depends on stl_pkg
interface stl_out_if import stl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_class;
  logic [3:0]             token_variant;
  logic [OffsetWidth-1:0] tok_offset;
  logic [OffsetWidth-1:0] token_length;
  logic [LineWidth-1:0]   line_number;
  logic [OffsetWidth-1:0] column_number;
  logic                   last_of_run;
  modport source (output valid, token_class, token_variant, tok_offset, token_length,
                  line_number, column_number, last_of_run, input ready);
  modport sink (input valid, token_class, token_variant, tok_offset, token_length,
                line_number, column_number, last_of_run, output ready);
endinterface

### rtl/source_token_lexer_unit.sv
// top level of the source token lexer: front scanner, record queue, token sender
// depends on stl_pkg, stl_in_if, stl_out_if, stl_front, stl_queue, stl_back
//
// in_i takes one transaction per byte of source text (op 0) and one with op 1 at
// end of file. out_o gives tokens: class, variant, begin offset, length, line and
// column, with last_of_run set on the last token that a transaction causes.
// A byte transaction gives zero, one or two tokens; end of file gives one or two,
// always closing with an end token, after which the scanner starts a new text.
// Throughput: one input transaction per cycle while the four-entry record queue
// has room; the output sends one token per cycle while out_o is ready. The record
// is written to the queue and then loaded into the output register, and only
// then is the first token of the transaction valid on out_o.
// When out_o stalls the queue fills and in_i.ready drops; nothing is lost.
// Reset clears scanner state, queue pointers and the output valid; the first
// byte after reset is at offset 0, line 0, column 0.
// Offsets, lengths, lines and columns saturate at their field maximum.
module source_token_lexer_unit import stl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  stl_in_if.sink    in_i,
  stl_out_if.source out_o
);

  stl_rec_t      push_rec, head;
  stl_q_status_t q_status;
  logic          push, pop, fe_ready;

  stl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_byte_i  (in_i.source_byte),
    .q_full_i   (q_status.full),
    .in_ready_o (fe_ready),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  assign in_i.ready = fe_ready;

  stl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  stl_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .status_i (q_status),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> !in_i.ready) else $error("input accepted with full queue");

  a_eof_gives_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.op == OP_EOF) |=> (!q_status.empty || out_o.valid))
    else $error("end of file left no token");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.token_class == CLS_END) |-> out_o.last_of_run)
    else $error("end token not last of run");

endmodule

### rtl/stl_front.sv
// lexer front end: scans one byte per cycle while the queue has room and builds the tokens it causes
// depends on stl_pkg; feeds stl_queue
module stl_front import stl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  input  logic [7:0] in_byte_i,
  input  logic     q_full_i,
  output logic     in_ready_o,
  output logic     push_o,
  output stl_rec_t rec_o
);

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_WORD, MODE_INT, MODE_REAL, MODE_STR, MODE_SLASH, MODE_MINUS,
    MODE_COLON, MODE_EQUAL, MODE_LINEC, MODE_BLOCK, MODE_STAR
  } lex_mode_e;

  localparam logic [OffsetWidth-1:0] OffMax  = {OffsetWidth{1'b1}};
  localparam logic [LineWidth-1:0]   LineMax = {LineWidth{1'b1}};

  lex_mode_e              mode_q, mode_d;
  logic [47:0]            word_q, word_d;
  logic [2:0]             wcnt_q, wcnt_d;
  logic [OffsetWidth-1:0] cur_q, cur_d, tstart_q, tstart_d, lstart_q, lstart_d;
  logic [OffsetWidth-1:0] tcol_q, tcol_d;
  logic [LineWidth-1:0]   line_q, line_d, tline_q, tline_d;
  logic                   esc_q, esc_d, halt_q, halt_d;

  logic                   accept;
  logic [7:0]             c;
  logic [OffsetWidth-1:0] nxt, cur_col;
  logic                   is_alpha, is_digit, is_ident, is_ws;

  lex_mode_e  disp_mode;
  logic       disp_start, disp_word, disp_single, disp_halt;
  logic [3:0] disp_cls, disp_var;

  logic                   do_disp;
  logic                   pa_v, sb_v, sb_zero;
  logic [3:0]             pa_cls, pa_var, sb_cls, sb_var;
  logic [OffsetWidth-1:0] pa_end;
  logic [7:0]             wclass;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign c          = in_byte_i;
  assign nxt        = (cur_q == OffMax) ? cur_q : cur_q + 1'b1;
  assign cur_col    = (cur_q >= lstart_q) ? cur_q - lstart_q : '0;
  assign is_alpha   = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  assign is_digit   = (c >= "0" && c <= "9");
  assign is_ident   = is_alpha || is_digit || c == "_";
  assign is_ws      = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign wclass     = classify_word(word_q, wcnt_q);

  // what a byte does when it starts a fresh token
  always_comb begin
    disp_mode   = MODE_IDLE;
    disp_start  = 1'b0;
    disp_word   = 1'b0;
    disp_single = 1'b0;
    disp_halt   = 1'b0;
    disp_cls    = CLS_ERROR;
    disp_var    = ERR_BAD_BYTE;
    if (is_ws) begin
    end else if (is_alpha) begin
      disp_start = 1'b1;
      disp_word  = 1'b1;
      disp_mode  = MODE_WORD;
    end else if (is_digit) begin
      disp_start = 1'b1;
      disp_mode  = MODE_INT;
    end else begin
      case (c)
        "\"": begin disp_start = 1'b1; disp_mode = MODE_STR;   end
        "/":  begin disp_start = 1'b1; disp_mode = MODE_SLASH; end
        "-":  begin disp_start = 1'b1; disp_mode = MODE_MINUS; end
        ":":  begin disp_start = 1'b1; disp_mode = MODE_COLON; end
        "=":  begin disp_start = 1'b1; disp_mode = MODE_EQUAL; end
        ";":  begin disp_single = 1'b1; disp_cls = CLS_PUNCT; disp_var = PU_SEMI;     end
        "{":  begin disp_single = 1'b1; disp_cls = CLS_PUNCT; disp_var = PU_LBRACE;   end
        "}":  begin disp_single = 1'b1; disp_cls = CLS_PUNCT; disp_var = PU_RBRACE;   end
        "(":  begin disp_single = 1'b1; disp_cls = CLS_PUNCT; disp_var = PU_LPAREN;   end
        ")":  begin disp_single = 1'b1; disp_cls = CLS_PUNCT; disp_var = PU_RPAREN;   end
        "[":  begin disp_single = 1'b1; disp_cls = CLS_PUNCT; disp_var = PU_LBRACKET; end
        "]":  begin disp_single = 1'b1; disp_cls = CLS_PUNCT; disp_var = PU_RBRACKET; end
        ",":  begin disp_single = 1'b1; disp_cls = CLS_PUNCT; disp_var = PU_COMMA;    end
        "!":  begin disp_single = 1'b1; disp_cls = CLS_OPERATOR; disp_var = OP_BANG;    end
        "+":  begin disp_single = 1'b1; disp_cls = CLS_OPERATOR; disp_var = OP_PLUS;    end
        "*":  begin disp_single = 1'b1; disp_cls = CLS_OPERATOR; disp_var = OP_STAR;    end
        "<":  begin disp_single = 1'b1; disp_cls = CLS_OPERATOR; disp_var = OP_LESS;    end
        ">":  begin disp_single = 1'b1; disp_cls = CLS_OPERATOR; disp_var = OP_GREATER; end
        "%":  begin disp_single = 1'b1; disp_cls = CLS_OPERATOR; disp_var = OP_PERCENT; end
        default: begin
          disp_single = 1'b1;
          disp_halt   = 1'b1;
          disp_cls    = CLS_ERROR;
          disp_var    = ERR_BAD_BYTE;
        end
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    word_d   = word_q;
    wcnt_d   = wcnt_q;
    cur_d    = cur_q;
    tstart_d = tstart_q;
    lstart_d = lstart_q;
    tcol_d   = tcol_q;
    line_d   = line_q;
    tline_d  = tline_q;
    esc_d    = esc_q;
    halt_d   = halt_q;
    do_disp  = 1'b0;
    pa_v     = 1'b0;
    pa_cls   = CLS_IDENT;
    pa_var   = VAR_NONE;
    pa_end   = cur_q;
    sb_v     = 1'b0;
    sb_zero  = 1'b0;
    sb_cls   = disp_cls;
    sb_var   = disp_var;
    if (accept && in_op_i == OP_BYTE) begin
      if (!halt_q) begin
        unique case (mode_q)
          MODE_WORD: begin
            if (is_ident) begin
              if (wcnt_q < 3'd6) begin
                word_d = {word_q[39:0], c};
                wcnt_d = wcnt_q + 3'd1;
              end else begin
                wcnt_d = 3'd7;
              end
            end else begin
              pa_v    = 1'b1;
              pa_cls  = wclass[7:4];
              pa_var  = wclass[3:0];
              do_disp = 1'b1;
            end
          end
          MODE_INT: begin
            if (c == ".") begin
              mode_d = MODE_REAL;
            end else if (!is_digit) begin
              pa_v    = 1'b1;
              pa_cls  = CLS_INTEGER;
              do_disp = 1'b1;
            end
          end
          MODE_REAL: begin
            if (!is_digit) begin
              pa_v    = 1'b1;
              pa_cls  = CLS_REAL;
              do_disp = 1'b1;
            end
          end
          MODE_STR: begin
            if (esc_q) begin
              esc_d = 1'b0;
            end else if (c == "\\") begin
              esc_d = 1'b1;
            end else if (c == "\"") begin
              pa_v   = 1'b1;
              pa_cls = CLS_STRING;
              pa_end = nxt;
              mode_d = MODE_IDLE;
            end
          end
          MODE_SLASH: begin
            if (c == "/") begin
              mode_d = MODE_LINEC;
            end else if (c == "*") begin
              mode_d = MODE_BLOCK;
            end else begin
              pa_v    = 1'b1;
              pa_cls  = CLS_OPERATOR;
              pa_var  = OP_SLASH;
              do_disp = 1'b1;
            end
          end
          MODE_MINUS: begin
            pa_v = 1'b1;
            if (c == ">") begin
              pa_cls = CLS_PUNCT;
              pa_var = PU_ARROW;
              pa_end = nxt;
              mode_d = MODE_IDLE;
            end else begin
              pa_cls  = CLS_OPERATOR;
              pa_var  = OP_MINUS;
              do_disp = 1'b1;
            end
          end
          MODE_COLON: begin
            mode_d = MODE_IDLE;
            pa_v   = 1'b1;
            pa_end = nxt;
            if (c == "=") begin
              pa_cls = CLS_PUNCT;
              pa_var = PU_ASSIGN;
            end else if (c == ":") begin
              pa_cls = CLS_OPERATOR;
              pa_var = OP_SCOPE;
            end else begin
              pa_cls = CLS_ERROR;
              pa_var = ERR_BAD_BYTE;
              pa_end = cur_q;
              halt_d = 1'b1;
            end
          end
          MODE_EQUAL: begin
            mode_d = MODE_IDLE;
            pa_v   = 1'b1;
            if (c == "=") begin
              pa_cls = CLS_OPERATOR;
              pa_var = OP_EQEQ;
              pa_end = nxt;
            end else begin
              pa_cls = CLS_ERROR;
              pa_var = ERR_BAD_BYTE;
              halt_d = 1'b1;
            end
          end
          MODE_LINEC: begin
            if (c == 8'h0a) mode_d = MODE_IDLE;
          end
          MODE_BLOCK: begin
            if (c == "*") mode_d = MODE_STAR;
          end
          MODE_STAR: begin
            if (c == "/") mode_d = MODE_IDLE;
            else if (c != "*") mode_d = MODE_BLOCK;
          end
          default: do_disp = 1'b1;
        endcase
        if (do_disp) begin
          mode_d = disp_mode;
          sb_v   = disp_single;
          if (disp_halt) halt_d = 1'b1;
          if (disp_start) begin
            tstart_d = cur_q;
            tline_d  = line_q;
            tcol_d   = cur_col;
          end
          if (disp_word) begin
            word_d = {40'd0, c};
            wcnt_d = 3'd1;
          end
          if (c == "\"") esc_d = 1'b0;
        end
      end
      if (c == 8'h0a) begin
        line_d   = (line_q == LineMax) ? line_q : line_q + 1'b1;
        lstart_d = nxt;
      end
      cur_d = nxt;
    end else if (accept) begin
      if (!halt_q) begin
        pa_v = 1'b1;
        unique case (mode_q)
          MODE_WORD: begin
            pa_cls = wclass[7:4];
            pa_var = wclass[3:0];
          end
          MODE_INT:   pa_cls = CLS_INTEGER;
          MODE_REAL:  pa_cls = CLS_REAL;
          MODE_STR:   begin pa_cls = CLS_ERROR; pa_var = ERR_OPEN_STR; end
          MODE_SLASH: begin pa_cls = CLS_OPERATOR; pa_var = OP_SLASH; end
          MODE_MINUS: begin pa_cls = CLS_OPERATOR; pa_var = OP_MINUS; end
          MODE_COLON, MODE_EQUAL: begin pa_cls = CLS_ERROR; pa_var = ERR_BAD_BYTE; end
          default: pa_v = 1'b0;
        endcase
      end
      sb_v     = 1'b1;
      sb_zero  = 1'b1;
      sb_cls   = CLS_END;
      sb_var   = VAR_NONE;
      mode_d   = MODE_IDLE;
      word_d   = '0;
      wcnt_d   = '0;
      cur_d    = '0;
      tstart_d = '0;
      lstart_d = '0;
      tcol_d   = '0;
      line_d   = '0;
      tline_d  = '0;
      esc_d    = 1'b0;
      halt_d   = 1'b0;
    end
  end

  always_comb begin
    rec_o.a_valid         = pa_v;
    rec_o.b_valid         = sb_v;
    rec_o.a.token_class   = pa_cls;
    rec_o.a.token_variant = pa_var;
    rec_o.a.tok_offset    = tstart_q;
    rec_o.a.token_length  = pa_end - tstart_q;
    rec_o.a.line_number   = tline_q;
    rec_o.a.column_number = tcol_q;
    rec_o.b.token_class   = sb_cls;
    rec_o.b.token_variant = sb_var;
    rec_o.b.tok_offset    = cur_q;
    rec_o.b.token_length  = sb_zero ? '0 : nxt - cur_q;
    rec_o.b.line_number   = line_q;
    rec_o.b.column_number = cur_col;
  end

  assign push_o = accept && (pa_v || sb_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      word_q   <= '0;
      wcnt_q   <= '0;
      cur_q    <= '0;
      tstart_q <= '0;
      lstart_q <= '0;
      tcol_q   <= '0;
      line_q   <= '0;
      tline_q  <= '0;
      esc_q    <= 1'b0;
      halt_q   <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      word_q   <= word_d;
      wcnt_q   <= wcnt_d;
      cur_q    <= cur_d;
      tstart_q <= tstart_d;
      lstart_q <= lstart_d;
      tcol_q   <= tcol_d;
      line_q   <= line_d;
      tline_q  <= tline_d;
      esc_q    <= esc_d;
      halt_q   <= halt_d;
    end
  end

endmodule

### rtl/stl_queue.sv
// short queue of per-transaction token records between front and back
// depends on stl_pkg
module stl_queue import stl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stl_rec_t      push_rec_i,
  input  logic          pop_i,
  output stl_rec_t      head_o,
  output stl_q_status_t status_o
);

  stl_rec_t              mem_q [QueueDepth];
  logic [QueueAddrW-1:0] wr_q, rd_q;
  logic [QueueAddrW:0]   cnt_q;
  logic                  do_push, do_pop;

  assign status_o.full  = (cnt_q == QueueAddrW'(0) + (QueueAddrW+1)'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueueAddrW+1)'(do_push) - (QueueAddrW+1)'(do_pop);
    end
  end

endmodule

### rtl/stl_back.sv
// lexer back end: sends the tokens of each record through an output register, one per cycle while out_o is ready
// depends on stl_pkg; reads stl_queue
module stl_back import stl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stl_rec_t      head_i,
  input  stl_q_status_t status_i,
  output logic          pop_o,
  stl_out_if.source     out_o
);

  logic       out_valid_q;
  stl_token_t tok_q;
  logic       last_q;
  logic       second_q;
  logic       load, pick_a, sel_last;
  stl_token_t sel;

  assign load     = !status_i.empty && (!out_valid_q || out_o.ready);
  assign pick_a   = !second_q && head_i.a_valid;
  assign sel      = pick_a ? head_i.a : head_i.b;
  assign sel_last = !pick_a || !head_i.b_valid;
  assign pop_o    = load && sel_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        second_q    <= !sel_last;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= sel;
      last_q <= sel_last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.token_class   = tok_q.token_class;
  assign out_o.token_variant = tok_q.token_variant;
  assign out_o.tok_offset    = tok_q.tok_offset;
  assign out_o.token_length  = tok_q.token_length;
  assign out_o.line_number   = tok_q.line_number;
  assign out_o.column_number = tok_q.column_number;
  assign out_o.last_of_run   = last_q;

endmodule
